@@ rtl/sapq_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_pkg
// Types and codes shared by the sorted-array priority queue and its cells.
// ----------------------------------------------------------------------------
package sapq_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int STATUS_W     = 2;
    localparam int FILL_W       = 5;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_DELETE = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 2'd2;

    typedef struct packed {
        logic                       mode;
        logic signed [VALUE_W-1:0]  value;
    } t_in_req;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  out_value;
        logic [STATUS_W-1:0]        status;
        logic [FILL_W-1:0]          fill;
    } t_out_rsp;

    // broadcast to every cell of the row
    typedef struct packed {
        logic                       wr;
        logic                       mode;
        logic signed [VALUE_W-1:0]  value;
    } t_cell_cmd;

endpackage : sapq_pkg
`default_nettype wire

@@ rtl/sorted_array_priority_queue.sv @@
`default_nettype none
// Latency: the result of a request is valid in the cycle after it is accepted.
// Throughput: one request per cycle while the output is not stalled; every
// cell does one compare and one shift step per request.
// Reset clears the entry count and the output valid flag; cell contents stay
// undefined until written and are never read before that.
// ----------------------------------------------------------------------------
// sorted_array_priority_queue
// Min-priority queue kept as a row of cells sorted ascending from cell 0.
// ----------------------------------------------------------------------------
module sorted_array_priority_queue
    import sapq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_stall,
    input  wire t_in_req i_in_req,
    output logic        o_out_valid,
    input  wire         i_out_stall,
    output t_out_rsp    o_out_rsp
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_out_valid;
    t_out_rsp         r_out_rsp;
    t_out_rsp         n_out_rsp;

    logic             accept;
    logic             is_full;
    logic             is_empty;
    logic             op_ok;
    t_cell_cmd        cmd;

    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic                      cell_less  [CAPACITY];

    assign o_in_stall  = r_out_valid && i_out_stall;
    assign accept      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    assign is_full  = (r_count == CNT_W'(CAPACITY));
    assign is_empty = (r_count == '0);
    assign op_ok    = (i_in_req.mode == MODE_DELETE) ? !is_empty : !is_full;

    assign cmd.wr    = accept && op_ok;
    assign cmd.mode  = i_in_req.mode;
    assign cmd.value = i_in_req.value;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic                      left_less;
            logic signed [VALUE_W-1:0] left_value;
            logic signed [VALUE_W-1:0] right_value;

            if (gi == 0) begin : g_first
                // nothing sits left of the head, so the key lands here if not less
                assign left_less  = 1'b1;
                assign left_value = cell_value[gi];
            end else begin : g_inner
                assign left_less  = cell_less[gi-1];
                assign left_value = cell_value[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_value = cell_value[gi];
            end else begin : g_body
                assign right_value = cell_value[gi+1];
            end

            sapq_cell u_cell (
                .i_clk         (i_clk),
                .i_cmd         (cmd),
                .i_active      (r_count > CNT_W'(gi)),
                .i_left_less   (left_less),
                .i_left_value  (left_value),
                .i_right_value (right_value),
                .o_value       (cell_value[gi]),
                .o_less        (cell_less[gi])
            );
        end
    endgenerate

    always_comb begin
        n_count             = r_count;
        n_out_rsp.out_value = '0;
        n_out_rsp.status    = STATUS_OK;
        if (i_in_req.mode == MODE_DELETE) begin
            if (is_empty) begin
                n_out_rsp.status = STATUS_EMPTY;
            end else begin
                n_out_rsp.out_value = cell_value[0];
                n_count             = r_count - CNT_W'(1);
            end
        end else begin
            if (is_full) begin
                n_out_rsp.status = STATUS_OVERFLOW;
            end else begin
                n_count = r_count + CNT_W'(1);
            end
        end
        n_out_rsp.fill = FILL_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_rsp <= n_out_rsp;
        end
    end

endmodule : sorted_array_priority_queue
`default_nettype wire

@@ rtl/sapq_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// sapq_cell
// One slot of the sorted row: holds a value, compares it with the incoming
// key and takes the key, its left neighbor or its right neighbor.
// ----------------------------------------------------------------------------
module sapq_cell
    import sapq_pkg::*;
(
    input  wire                         i_clk,
    input  wire t_cell_cmd              i_cmd,
    input  wire                         i_active,
    input  wire                         i_left_less,
    input  wire logic signed [VALUE_W-1:0] i_left_value,
    input  wire logic signed [VALUE_W-1:0] i_right_value,
    output logic signed [VALUE_W-1:0]   o_value,
    output logic                        o_less
);

    logic signed [VALUE_W-1:0] r_value;
    logic signed [VALUE_W-1:0] n_value;

    // strictly less keeps equal keys behind the new one
    assign o_less  = i_active && (r_value < i_cmd.value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_cmd.mode == MODE_DELETE) begin
            n_value = i_right_value;
        end else if (!o_less) begin
            n_value = i_left_less ? i_cmd.value : i_left_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr) begin
            r_value <= n_value;
        end
    end

endmodule : sapq_cell
`default_nettype wire

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted-array min-priority queue: random and
// directed insert / delete-min requests, results checked against a local
// sorted-row predictor, with random request gaps and response stalls.
// ----------------------------------------------------------------------------
module tb;
    import sapq_pkg::*;

    localparam int CAPACITY   = CAPACITY_DEF;
    localparam int QUIET_MAX  = 2000;
    localparam int RAND_REQS  = 550;
    localparam int IDLE_PCT   = 21;
    localparam int HOLD_LEN   = 60;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        t_in_req req;
        bit      drain_first;
    } t_stim;

    logic     i_clk;
    logic     i_rst_n    = 1'b0;
    logic     i_in_valid = 1'b0;
    logic     o_in_stall;
    t_in_req  i_in_req   = '0;
    logic     o_out_valid;
    logic     i_out_stall = 1'b0;
    t_out_rsp o_out_rsp;

    t_stim    req_pending_q[$];
    t_out_rsp rsp_expect_q[$];

    // predictor copy of the queue contents
    logic signed [VALUE_W-1:0] pq_store[CAPACITY];
    int       pq_count    = 0;

    int       fail_count  = 0;
    int       sent_count  = 0;
    int       rsp_count   = 0;
    int       quiet_cycles = 0;
    int       hold_left   = 0;
    bit       hold_done   = 1'b0;
    bit       req_taken   = 1'b0;

    sorted_array_priority_queue #(
        .CAPACITY   (CAPACITY)
    ) u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out_rsp  (o_out_rsp)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // one request against the sorted row: returns the response it should give
    function automatic t_out_rsp pq_apply(input t_in_req req);
        t_out_rsp rsp;
        int       pos;
        rsp = '0;
        if (req.mode == MODE_INSERT) begin
            if (pq_count >= CAPACITY) begin
                rsp.status = STATUS_OVERFLOW;
            end else begin
                pos = 0;
                while (pos < pq_count && $signed(pq_store[pos]) < $signed(req.value))
                    pos++;
                for (int k = pq_count; k > pos; k--)
                    pq_store[k] = pq_store[k-1];
                pq_store[pos] = req.value;
                pq_count++;
            end
        end else begin
            if (pq_count == 0) begin
                rsp.status = STATUS_EMPTY;
            end else begin
                rsp.out_value = pq_store[0];
                for (int k = 1; k < pq_count; k++)
                    pq_store[k-1] = pq_store[k];
                pq_count--;
            end
        end
        rsp.fill = FILL_W'(pq_count);
        return rsp;
    endfunction

    task automatic queue_req(input logic mode, input logic signed [VALUE_W-1:0] value,
                             input bit drain_first = 1'b0);
        t_stim s;
        s.req.mode   = mode;
        s.req.value  = value;
        s.drain_first = drain_first;
        req_pending_q.push_back(s);
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 3)
            return $urandom;
        else if (sel <= 6)
            return $signed($urandom_range(0, 7)) - 4;
        else if (sel == 7)
            return VAL_MIN + $urandom_range(0, 3);
        else if (sel == 8)
            return VAL_MAX - $urandom_range(0, 3);
        else
            return $urandom_range(0, 1) ? 32'sd0 : -32'sd1;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        t_stim nxt;
        bit    calm;
        calm = (sent_count >= 200 && sent_count < 320);
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || req_taken) begin
            if (req_pending_q.size() == 0
                || (req_pending_q[0].drain_first && rsp_expect_q.size() != 0)
                || (!calm && $urandom_range(0, 99) < IDLE_PCT)) begin
                i_in_valid <= 1'b0;
            end else begin
                nxt = req_pending_q.pop_front();
                i_in_valid <= 1'b1;
                i_in_req   <= nxt.req;
                sent_count++;
            end
        end
    end

    // response side stall, with one long hold to back the queue up
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (!hold_done && rsp_count >= 150) begin
                hold_left = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (rsp_count >= 200 && rsp_count < 320) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
            end
        end
    end

    // monitor and checker
    always @(posedge i_clk) begin
        t_out_rsp want;
        bit       rsp_taken;
        if (!i_rst_n) begin
            req_taken    = 1'b0;
            quiet_cycles = 0;
        end else begin
            req_taken = i_in_valid && !o_in_stall;
            rsp_taken = o_out_valid && !i_out_stall;
            if (rsp_taken) begin
                rsp_count++;
                if (rsp_expect_q.size() == 0) begin
                    report_mismatch("response with no request outstanding");
                end else begin
                    want = rsp_expect_q.pop_front();
                    if (o_out_rsp.out_value !== want.out_value)
                        report_mismatch($sformatf("out_value got %0d want %0d",
                            o_out_rsp.out_value, want.out_value));
                    if (o_out_rsp.status !== want.status)
                        report_mismatch($sformatf("status got %0d want %0d",
                            o_out_rsp.status, want.status));
                    if (o_out_rsp.fill !== want.fill)
                        report_mismatch($sformatf("fill got %0d want %0d",
                            o_out_rsp.fill, want.fill));
                end
            end
            if (req_taken)
                rsp_expect_q.push_back(pq_apply(i_in_req));
            if (req_taken || rsp_taken)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QUIET_MAX) begin
                $display("watchdog: no progress for %0d cycles", QUIET_MAX);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial begin
        int insert_pct;
        // delete on an empty queue, with a value that must be ignored
        queue_req(MODE_DELETE, 32'sh5A5A_A5A5);
        // fill to capacity: extremes, duplicates, sign boundaries
        queue_req(MODE_INSERT, 32'sd0);
        queue_req(MODE_INSERT, -32'sd1);
        queue_req(MODE_INSERT, 32'sd1);
        queue_req(MODE_INSERT, VAL_MAX);
        queue_req(MODE_INSERT, VAL_MIN);
        queue_req(MODE_INSERT, 32'sd5);
        queue_req(MODE_INSERT, 32'sd5);
        queue_req(MODE_INSERT, -32'sd5);
        queue_req(MODE_INSERT, VAL_MAX);
        queue_req(MODE_INSERT, VAL_MIN);
        queue_req(MODE_INSERT, 32'sd100);
        queue_req(MODE_INSERT, -32'sd100);
        queue_req(MODE_INSERT, 32'sd7);
        queue_req(MODE_INSERT, 32'sd7);
        queue_req(MODE_INSERT, 32'sd3);
        queue_req(MODE_INSERT, 32'sd2);
        // insert into a full queue
        queue_req(MODE_INSERT, 32'sd42);
        repeat (5) queue_req(MODE_DELETE, $urandom);

        // random part in phases that lean toward filling, draining or neither
        insert_pct = 50;
        for (int n = 0; n < RAND_REQS; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(0, 2))
                    0: insert_pct = 80;
                    1: insert_pct = 20;
                    default: insert_pct = 50;
                endcase
            end
            if ($urandom_range(0, 99) < insert_pct)
                queue_req(MODE_INSERT, pick_value(), n == 275);
            else
                queue_req(MODE_DELETE, $urandom, n == 275);
        end

        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (req_pending_q.size() != 0 || i_in_valid || rsp_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ files.f @@
rtl/sapq_pkg.sv
rtl/sapq_cell.sv
rtl/sorted_array_priority_queue.sv
dv/tb.sv
